FILE: rtl/core/tlrs_pkg.sv
// Shared constants and types for the toroidal Life row stencil.
package tlrs_pkg;

    // Fixed field widths of the channels
    localparam int FIELD_W    = 64;
    localparam int ROWNUM_W   = 12;
    localparam int ROWS_CFG_W = 13;
    localparam int COLS_CFG_W = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Board limits
    localparam int MIN_DIM  = 3;
    localparam int MAX_ROWS = 4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_COLS = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(64);
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(64);

    // Which result of the held row goes out next
    typedef enum logic [1:0] {
        PH_MID,   // row k-1 from rows k-2, k-1, k
        PH_TAIL,  // row k from rows k-1, k and row 0
        PH_WRAP   // row 0 from row k, row 0, row 1; ends the generation
    } phase_t;

endpackage

FILE: rtl/core/tlrs_row_if.sv
// Input channel: one board row per word.
interface tlrs_row_if;
    logic                         valid;
    logic                         ready;
    logic [tlrs_pkg::FIELD_W-1:0] row_cells;

    modport source (output valid, output row_cells, input ready);
    modport sink   (input valid, input row_cells, output ready);
endinterface

FILE: rtl/core/tlrs_res_if.sv
// Result channel: one next-generation row per word.
interface tlrs_res_if;
    logic                          valid;
    logic                          ready;
    logic [tlrs_pkg::ROWNUM_W-1:0] row_number;
    logic [tlrs_pkg::FIELD_W-1:0]  next_cells;
    logic                          generation_done;

    modport source (output valid, output row_number, output next_cells,
                    output generation_done, input ready);
    modport sink   (input valid, input row_number, input next_cells,
                    input generation_done, output ready);
endinterface

FILE: rtl/core/tlrs_cfg_if.sv
// Configuration write channel: register index and write data.
interface tlrs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tlrs_pkg::CFG_IDX_W-1:0]  index;
    logic [tlrs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/tlrs_life_row.sv
// Combinational Life rule for one row with wraparound at the active width.
module tlrs_life_row #(
    parameter int ROW_WIDTH = 64,
    parameter int CW        = 7
) (
    input  logic [ROW_WIDTH-1:0] up,
    input  logic [ROW_WIDTH-1:0] mid,
    input  logic [ROW_WIDTH-1:0] down,
    input  logic [CW-1:0]        cols,
    output logic [ROW_WIDTH-1:0] next
);
    localparam int IW = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;

    logic [IW-1:0] last_col;
    logic          up_last;
    logic          mid_last;
    logic          down_last;

    // Column wrapped to the left of column 0
    assign last_col  = IW'(cols - CW'(1));
    assign up_last   = up[last_col];
    assign mid_last  = mid[last_col];
    assign down_last = down[last_col];

    // One independent neighbor count per column
    for (genvar j = 0; j < ROW_WIDTH; j++) begin : g_col
        logic       ul, ml, dl;
        logic       ur, mr, dr;
        logic [3:0] cnt;

        if (j == 0) begin : g_left_wrap
            assign ul = up_last;
            assign ml = mid_last;
            assign dl = down_last;
        end else begin : g_left
            assign ul = up[j-1];
            assign ml = mid[j-1];
            assign dl = down[j-1];
        end

        if (j == ROW_WIDTH - 1) begin : g_right_wrap
            assign ur = up[0];
            assign mr = mid[0];
            assign dr = down[0];
        end else begin : g_right
            logic wrap;
            assign wrap = (CW'(j + 1) == cols);
            assign ur   = wrap ? up[0]   : up[j+1];
            assign mr   = wrap ? mid[0]  : mid[j+1];
            assign dr   = wrap ? down[0] : down[j+1];
        end

        assign cnt = 4'(ul) + 4'(up[j]) + 4'(ur)
                   + 4'(ml) + 4'(mr)
                   + 4'(dl) + 4'(down[j]) + 4'(dr);

        // Birth on three, survival on two or three; nothing past the width
        assign next[j] = (CW'(j) < cols)
                       && ((cnt == 4'd3) || (mid[j] && (cnt == 4'd2)));
    end

endmodule

FILE: rtl/core/toroidal_life_row_stencil.sv
// Top level of the row-streamed toroidal Life stencil.
// One Life generation on a board_rows x board_cols torus, fed one row per word,
// top row first, bit j being column j. Rows are accepted one per cycle while the
// results side keeps up and no held row has results left. Once row r+1 has
// arrived, next-generation row r goes out; the first two rows of a generation
// give nothing, and the last row gives three words: rows n-2, n-1, then row 0
// with generation_done set. That last row keeps the input stalled until all
// three results have passed through the one Life row unit and output register.
// A result passes through the held-row snapshot and then the output register.
// Widths and heights outside 3..ROW_WIDTH and 3..4096 are clamped, input bits
// above the width are ignored and output bits above it are zero. Writing
// either register restarts the generation; write only while the block is idle.
module toroidal_life_row_stencil #(
    parameter int ROW_WIDTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    tlrs_row_if.sink   rows,
    tlrs_res_if.source results,
    tlrs_cfg_if.sink   cfg
);
    localparam int CW = $clog2(ROW_WIDTH + 1);

    // Configuration registers
    logic [tlrs_pkg::ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [tlrs_pkg::COLS_CFG_W-1:0] cols_cfg_reg;

    // Generation state
    logic [ROW_WIDTH-1:0]          first_row_reg, second_row_reg;
    logic [ROW_WIDTH-1:0]          older_row_reg, newer_row_reg;
    logic [tlrs_pkg::ROWNUM_W-1:0] row_counter_reg, row_counter_next;

    // Held row with its neighborhood snapshot
    logic                          s_valid_reg, s_valid_next;
    logic                          s_last_reg;
    tlrs_pkg::phase_t              s_phase_reg, s_phase_next;
    logic [tlrs_pkg::ROWNUM_W-1:0] s_k_reg;
    logic [ROW_WIDTH-1:0]          s_older_reg, s_newer_reg, s_cur_reg;
    logic [ROW_WIDTH-1:0]          s_first_reg, s_second_reg;

    // Output register
    logic                          o_valid_reg, o_valid_next;
    logic [tlrs_pkg::ROWNUM_W-1:0] o_row_reg;
    logic [ROW_WIDTH-1:0]          o_cells_reg;
    logic                          o_done_reg;

    logic [tlrs_pkg::ROWS_CFG_W-1:0] eff_rows;
    logic [CW-1:0]                   eff_cols;
    logic [ROW_WIDTH-1:0]            col_mask;
    logic [ROW_WIDTH-1:0]            cur;
    logic                            accept, cfg_write;
    logic                            has_mid, is_last;
    logic                            advance, finish;
    logic [ROW_WIDTH-1:0]            sel_up, sel_mid, sel_down, life_out;
    logic [tlrs_pkg::ROWNUM_W-1:0]   sel_row;
    logic                            sel_done;

    // Clamp the board size
    always_comb
    begin
        if (rows_cfg_reg < tlrs_pkg::ROWS_CFG_W'(tlrs_pkg::MIN_DIM))
            eff_rows = tlrs_pkg::ROWS_CFG_W'(tlrs_pkg::MIN_DIM);
        else if (rows_cfg_reg > tlrs_pkg::ROWS_CFG_W'(tlrs_pkg::MAX_ROWS))
            eff_rows = tlrs_pkg::ROWS_CFG_W'(tlrs_pkg::MAX_ROWS);
        else
            eff_rows = rows_cfg_reg;

        if (cols_cfg_reg < tlrs_pkg::COLS_CFG_W'(tlrs_pkg::MIN_DIM))
            eff_cols = CW'(tlrs_pkg::MIN_DIM);
        else if (cols_cfg_reg > tlrs_pkg::COLS_CFG_W'(ROW_WIDTH))
            eff_cols = CW'(ROW_WIDTH);
        else
            eff_cols = CW'(cols_cfg_reg);
    end

    for (genvar j = 0; j < ROW_WIDTH; j++) begin : g_mask
        assign col_mask[j] = (CW'(j) < eff_cols);
    end

    assign cur = rows.row_cells[ROW_WIDTH-1:0] & col_mask;

    // Handshakes; only a write to a known register counts
    assign cfg.ready  = 1'b1;
    assign cfg_write  = cfg.valid && ((cfg.index == tlrs_pkg::REG_BOARD_ROWS)
                        || (cfg.index == tlrs_pkg::REG_BOARD_COLS));
    assign advance    = s_valid_reg && (!o_valid_reg || results.ready);
    assign finish     = advance && ((s_phase_reg == tlrs_pkg::PH_WRAP)
                        || ((s_phase_reg == tlrs_pkg::PH_MID) && !s_last_reg));
    assign rows.ready = !s_valid_reg || finish;
    assign accept     = rows.valid && rows.ready;

    // What the incoming row will produce
    assign has_mid = (row_counter_reg >= tlrs_pkg::ROWNUM_W'(2));
    assign is_last = ({1'b0, row_counter_reg} + tlrs_pkg::ROWS_CFG_W'(1)) >= eff_rows;

    // Row counter
    always_comb
    begin
        row_counter_next = row_counter_reg;
        if (cfg_write)
            row_counter_next = '0;
        else if (accept)
            row_counter_next = is_last ? '0 : row_counter_reg + tlrs_pkg::ROWNUM_W'(1);
    end

    // Configuration and generation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg    <= tlrs_pkg::ROWS_RESET;
            cols_cfg_reg    <= tlrs_pkg::COLS_RESET;
            row_counter_reg <= '0;
            first_row_reg   <= '0;
            second_row_reg  <= '0;
            older_row_reg   <= '0;
            newer_row_reg   <= '0;
        end
        else
        begin
            row_counter_reg <= row_counter_next;
            if (cfg_write && (cfg.index == tlrs_pkg::REG_BOARD_ROWS))
                rows_cfg_reg <= cfg.data[tlrs_pkg::ROWS_CFG_W-1:0];
            if (cfg_write && (cfg.index == tlrs_pkg::REG_BOARD_COLS))
                cols_cfg_reg <= cfg.data[tlrs_pkg::COLS_CFG_W-1:0];
            if (accept)
            begin
                if (row_counter_reg == tlrs_pkg::ROWNUM_W'(0))
                    first_row_reg <= cur;
                if (row_counter_reg == tlrs_pkg::ROWNUM_W'(1))
                    second_row_reg <= cur;
                older_row_reg <= newer_row_reg;
                newer_row_reg <= cur;
            end
        end
    end

    // Held row control: next state
    always_comb
    begin
        s_valid_next = s_valid_reg;
        s_phase_next = s_phase_reg;
        if (accept)
        begin
            s_valid_next = has_mid || is_last;
            s_phase_next = has_mid ? tlrs_pkg::PH_MID : tlrs_pkg::PH_TAIL;
        end
        else if (finish)
            s_valid_next = 1'b0;
        else if (advance)
        begin
            case (s_phase_reg)
                tlrs_pkg::PH_MID:  s_phase_next = tlrs_pkg::PH_TAIL;
                tlrs_pkg::PH_TAIL: s_phase_next = tlrs_pkg::PH_WRAP;
                default:           s_phase_next = tlrs_pkg::PH_WRAP;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            s_phase_reg <= tlrs_pkg::PH_MID;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            s_phase_reg <= s_phase_next;
        end
    end

    // Neighborhood snapshot of the accepted row
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_last_reg   <= is_last;
            s_k_reg      <= row_counter_reg;
            s_older_reg  <= older_row_reg;
            s_newer_reg  <= newer_row_reg;
            s_cur_reg    <= cur;
            s_first_reg  <= (row_counter_reg == tlrs_pkg::ROWNUM_W'(0)) ? cur : first_row_reg;
            s_second_reg <= second_row_reg;
        end
    end

    // Pick the three rows and tag for the current result
    always_comb
    begin
        case (s_phase_reg)
            tlrs_pkg::PH_TAIL:
            begin
                sel_up   = s_newer_reg;
                sel_mid  = s_cur_reg;
                sel_down = s_first_reg;
                sel_row  = s_k_reg;
                sel_done = 1'b0;
            end
            tlrs_pkg::PH_WRAP:
            begin
                sel_up   = s_cur_reg;
                sel_mid  = s_first_reg;
                sel_down = s_second_reg;
                sel_row  = '0;
                sel_done = 1'b1;
            end
            default:
            begin
                sel_up   = s_older_reg;
                sel_mid  = s_newer_reg;
                sel_down = s_cur_reg;
                sel_row  = s_k_reg - tlrs_pkg::ROWNUM_W'(1);
                sel_done = 1'b0;
            end
        endcase
    end

    tlrs_life_row #(
        .ROW_WIDTH (ROW_WIDTH),
        .CW        (CW)
    ) u_life_row (
        .up   (sel_up),
        .mid  (sel_mid),
        .down (sel_down),
        .cols (eff_cols),
        .next (life_out)
    );

    // Output register
    always_comb
    begin
        o_valid_next = o_valid_reg;
        if (advance)
            o_valid_next = 1'b1;
        else if (results.ready)
            o_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else
            o_valid_reg <= o_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o_row_reg   <= sel_row;
            o_cells_reg <= life_out;
            o_done_reg  <= sel_done;
        end
    end

    assign results.valid           = o_valid_reg;
    assign results.row_number      = o_row_reg;
    assign results.next_cells      = tlrs_pkg::FIELD_W'(o_cells_reg);
    assign results.generation_done = o_done_reg;

endmodule

FILE: rtl/core/tlrs_checker.sv
// Port-level assertions for the Life row stencil, bound to the top level.
module tlrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [tlrs_pkg::ROWNUM_W-1:0] res_row_number,
    input logic [tlrs_pkg::FIELD_W-1:0]  res_next_cells,
    input logic                          res_done
);

    // Only the row 0 word closes a generation, and every row 0 word does
    a_done_is_row0: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_done == (res_row_number == tlrs_pkg::ROWNUM_W'(0))))
        else $error("generation_done does not match row 0");

    // Two generation ends never come back to back
    a_no_double_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && res_done) |=> !(res_valid && res_done))
        else $error("generation end repeated");

    // A stalled result word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_row_number)
            && $stable(res_next_cells) && $stable(res_done)))
        else $error("stalled result word changed");

endmodule

bind toroidal_life_row_stencil tlrs_checker u_tlrs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (results.valid),
    .res_ready      (results.ready),
    .res_row_number (results.row_number),
    .res_next_cells (results.next_cells),
    .res_done       (results.generation_done)
);

FILE: tb/sv/toroidal_life_row_stencil_test.sv
// Testbench for the toroidal Life row stencil: directed and random boards, checked per word.
`timescale 1ns / 100ps

module toroidal_life_row_stencil_test;
    import tlrs_pkg::*;

    localparam int          ROW_WIDTH    = 64;
    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 5;
    localparam int          IDLE_PCT     = 17;
    localparam int          SETTLE       = 6;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          MAX_REPORTED = 10;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // Indexes outside the register list; writes there change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic [ROWNUM_W-1:0] row_number;
        logic [FIELD_W-1:0]  next_cells;
        logic                generation_done;
    } life_row_result_t;

    logic clk;
    logic rst_n;

    tlrs_row_if row_ch ();
    tlrs_res_if res_ch ();
    tlrs_cfg_if cfg_ch ();

    toroidal_life_row_stencil #(
        .ROW_WIDTH (ROW_WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rows    (row_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    // Board model: registers, saved rows and position in the generation
    logic [ROWS_CFG_W-1:0] height_reg;
    logic [COLS_CFG_W-1:0] width_reg;
    logic [FIELD_W-1:0]    gen_row0;
    logic [FIELD_W-1:0]    gen_row1;
    logic [FIELD_W-1:0]    row_above;
    logic [FIELD_W-1:0]    row_mid;
    int unsigned           rows_seen;

    life_row_result_t pending_next_rows[$];

    int unsigned fail_count;
    int unsigned cycle_count;
    bit          steady;
    bit          hold_request;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Cycle counter and watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    function automatic int unsigned board_height();
        int unsigned h;
        h = height_reg;
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > MAX_ROWS) h = MAX_ROWS;
        return h;
    endfunction

    function automatic int unsigned board_width();
        int unsigned w;
        w = width_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > ROW_WIDTH) w = ROW_WIDTH;
        return w;
    endfunction

    // Life rule for the middle row; columns wrap at the active width
    function automatic logic [FIELD_W-1:0] life_rule_row(
        logic [FIELD_W-1:0] up, logic [FIELD_W-1:0] mid, logic [FIELD_W-1:0] down,
        int unsigned w);
        logic [FIELD_W-1:0] res;
        int unsigned        j;
        int unsigned        l;
        int unsigned        r;
        int unsigned        n;
        res = '0;
        for (j = 0; j < w; j++)
        begin
            l = (j == 0) ? w - 1 : j - 1;
            r = (j + 1 == w) ? 0 : j + 1;
            n = int'(up[l]) + int'(up[j]) + int'(up[r]) + int'(mid[l]) + int'(mid[r])
              + int'(down[l]) + int'(down[j]) + int'(down[r]);
            if (n == 3 || (mid[j] && n == 2))
                res[j] = 1'b1;
        end
        return res;
    endfunction

    // One accepted row: queue whatever next-generation rows it completes
    function automatic void advance_board_model(logic [FIELD_W-1:0] cells);
        int unsigned        h;
        int unsigned        w;
        int unsigned        k;
        logic [FIELD_W-1:0] cur;
        h = board_height();
        w = board_width();
        k = rows_seen;
        cur = (w >= FIELD_W) ? cells : cells & ((64'd1 << w) - 64'd1);
        if (k == 0)
            gen_row0 = cur;
        else if (k == 1)
            gen_row1 = cur;
        if (k >= 2)
            pending_next_rows.push_back('{row_number: ROWNUM_W'(k - 1),
                next_cells: life_rule_row(row_above, row_mid, cur, w), generation_done: 1'b0});
        if (k + 1 >= h)
        begin
            pending_next_rows.push_back('{row_number: ROWNUM_W'(k),
                next_cells: life_rule_row(row_mid, cur, gen_row0, w), generation_done: 1'b0});
            pending_next_rows.push_back('{row_number: '0,
                next_cells: life_rule_row(cur, gen_row0, gen_row1, w), generation_done: 1'b1});
            rows_seen = 0;
        end
        else
            rows_seen = k + 1;
        row_above = row_mid;
        row_mid = cur;
    endfunction

    // Register write in the model; a known register restarts the generation
    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        if (idx == REG_BOARD_ROWS)
        begin
            height_reg = data[ROWS_CFG_W-1:0];
            rows_seen = 0;
        end
        else if (idx == REG_BOARD_COLS)
        begin
            width_reg = data[COLS_CFG_W-1:0];
            rows_seen = 0;
        end
    endfunction

    function automatic void note_failure(string what, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTED)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endfunction

    // Result side ready: random idling, long hold-off on request, none when steady
    initial
    begin : result_ready_drive
        int unsigned hold_left;
        hold_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (steady)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each result word with the oldest pending row
    always @(posedge clk)
    begin : check_results
        life_row_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_next_rows.size() == 0)
                note_failure("unexpected word", '0, res_ch.next_cells);
            else
            begin
                want = pending_next_rows.pop_front();
                if (res_ch.row_number !== want.row_number)
                    note_failure("row_number", want.row_number, res_ch.row_number);
                if (res_ch.next_cells !== want.next_cells)
                    note_failure("next_cells", want.next_cells, res_ch.next_cells);
                if (res_ch.generation_done !== want.generation_done)
                    note_failure("generation_done", want.generation_done,
                                 res_ch.generation_done);
            end
        end
    end

    // Offer one row, with a random gap first, and wait for it to be taken
    task automatic send_row(input logic [FIELD_W-1:0] cells);
        @(negedge clk);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                row_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        row_ch.valid <= 1'b1;
        row_ch.row_cells <= cells;
        do
            @(posedge clk);
        while (!row_ch.ready);
        advance_board_model(cells);
    endtask

    task automatic send_random_rows(input int unsigned count);
        repeat (count)
            send_row({$urandom, $urandom});
    endtask

    // Stop offering rows and let every pending word drain
    task automatic settle();
        @(negedge clk);
        row_ch.valid <= 1'b0;
        while (pending_next_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_reg_write(idx, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Reset size 64 x 64: full rows, horizontal wrap, alternating columns
    task automatic test_default_board();
        send_row(64'hFFFF_FFFF_FFFF_FFFF);
        send_row(64'h0000_0000_0000_0000);
        send_row(64'h8000_0000_0000_0001);
        send_row(64'hAAAA_AAAA_AAAA_AAAA);
        send_row(64'h5555_5555_5555_5555);
    endtask

    // A write mid-generation starts a new one
    task automatic test_restart_on_write();
        settle();
        write_reg(REG_BOARD_COLS, CFG_DATA_W'(64));
        send_row(64'h0000_0000_0000_0007);
        send_row(64'h8000_0000_0000_0004);
        send_row(64'h0000_0000_0000_0002);
    endtask

    // 3 x 3 torus, two generations; bits above the width must be ignored
    task automatic test_smallest_board();
        settle();
        write_reg(REG_BOARD_ROWS, CFG_DATA_W'(3));
        write_reg(REG_BOARD_COLS, CFG_DATA_W'(3));
        send_row(64'hFFFF_FFFF_FFFF_FFF2);
        send_row(64'hFFFF_FFFF_FFFF_FFF7);
        send_row(64'hFFFF_FFFF_FFFF_FFF0);
        send_row(64'h0000_0000_0000_0007);
        send_row(64'h0000_0000_0000_0002);
        send_row(64'h0000_0000_0000_0005);
    endtask

    // Sizes below 3 and above the row width clamp; unused data bits dropped
    task automatic test_clamped_sizes();
        settle();
        write_reg(REG_BOARD_ROWS, CFG_DATA_W'(0));
        write_reg(REG_BOARD_COLS, CFG_DATA_W'(0));
        send_row(64'h0000_0000_0000_0001);
        send_row(64'h0000_0000_0000_0003);
        send_row(64'hF0F0_0000_0000_0006);
        settle();
        write_reg(REG_BOARD_ROWS, 16'hE002);
        write_reg(REG_BOARD_COLS, 16'hFFFF);
        send_row(64'hC000_0000_0000_0003);
        send_row(64'h8000_0001_8000_0001);
        send_row(64'h0123_4567_89AB_CDEF);
    endtask

    // Writes to unused indexes leave both size and row count alone
    task automatic test_ignored_index();
        settle();
        write_reg(REG_BOARD_ROWS, CFG_DATA_W'(5));
        write_reg(REG_BOARD_COLS, CFG_DATA_W'(8));
        send_row(64'h0000_0000_0000_001C);
        send_row(64'h0000_0000_0000_0081);
        settle();
        write_reg(REG_UNUSED_FIRST, 16'hFFFF);
        write_reg(REG_UNUSED_LAST, CFG_DATA_W'(3));
        send_row(64'h0000_0000_0000_0042);
        send_row(64'hFFFF_FFFF_FFFF_FF18);
        send_row(64'h0000_0000_0000_00E7);
    endtask

    // Random small boards: mostly whole generations, some cut short, some noise writes
    task automatic test_random_boards();
        int unsigned items;
        int unsigned height;
        int unsigned count;
        int unsigned split;
        int unsigned i;
        items = 0;
        while (items < 40)
        begin
            settle();
            if ($urandom_range(0, 4) != 0)
                write_reg(REG_BOARD_ROWS, CFG_DATA_W'($urandom_range(0, 7) << 13)
                                        | CFG_DATA_W'($urandom_range(0, 10)));
            if ($urandom_range(0, 4) != 0)
                write_reg(REG_BOARD_COLS, {9'($urandom), 7'($urandom_range(0, 70))});
            height = board_height();
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, height - 1);
            else
                count = height * $urandom_range(1, 2);
            split = ($urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : count;
            for (i = 0; i < count; i++)
            begin
                if (i == split)
                begin
                    settle();
                    write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                              CFG_DATA_W'($urandom));
                end
                send_row({$urandom, $urandom});
                items++;
            end
        end
    endtask

    // Receiver holds off while rows keep coming, so the input must stall
    task automatic test_output_backpressure();
        settle();
        write_reg(REG_BOARD_ROWS, CFG_DATA_W'(4));
        write_reg(REG_BOARD_COLS, CFG_DATA_W'(16));
        hold_request = 1'b1;
        send_random_rows(24);
    endtask

    // One full 32 x 64 generation with no idling on either side
    task automatic test_steady_stream();
        settle();
        steady = 1'b1;
        write_reg(REG_BOARD_ROWS, CFG_DATA_W'(32));
        write_reg(REG_BOARD_COLS, CFG_DATA_W'(64));
        send_random_rows(32);
        settle();
        steady = 1'b0;
    endtask

    // Tallest board: height clamps to the row limit, so a short run never wraps
    task automatic test_tallest_board();
        settle();
        write_reg(REG_BOARD_ROWS, 16'hFFFF);
        write_reg(REG_BOARD_COLS, CFG_DATA_W'($urandom_range(3, 12)));
        send_random_rows(20);
    endtask

    // Main sequence
    initial
    begin
        height_reg = ROWS_RESET;
        width_reg = COLS_RESET;
        gen_row0 = '0;
        gen_row1 = '0;
        row_above = '0;
        row_mid = '0;
        rows_seen = 0;
        fail_count = 0;
        steady = 1'b0;
        hold_request = 1'b0;
        rst_n = 1'b0;
        row_ch.valid = 1'b0;
        row_ch.row_cells = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_board();
        test_restart_on_write();
        test_smallest_board();
        test_clamped_sizes();
        test_ignored_index();
        test_random_boards();
        test_output_backpressure();
        test_steady_stream();
        test_tallest_board();
        settle();

        if (fail_count == 0 && pending_next_rows.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/tlrs_pkg.sv
rtl/core/tlrs_row_if.sv
rtl/core/tlrs_res_if.sv
rtl/core/tlrs_cfg_if.sv
rtl/core/tlrs_life_row.sv
rtl/core/toroidal_life_row_stencil.sv
rtl/core/tlrs_checker.sv
tb/sv/toroidal_life_row_stencil_test.sv
